### rtl/core/dcss_pkg.sv
`default_nettype none

package dcss_pkg;

  // line geometry
  localparam int DEFAULT_LINE_SLOTS = 122;

  localparam logic [5:0] WIDE_INDEX_START = 6'd13;
  localparam logic [6:0] FETCH_LAST_SLOT  = 7'd108;
  localparam logic [6:0] REFRESH_FIRST    = 7'd28;
  localparam logic [6:0] REFRESH_LAST     = 7'd60;
  localparam logic [6:0] FREE_FROM        = 7'd114;
  localparam logic [6:0] CPU_COUNT_MAX    = 7'd127;

  // fetch window length is twice the per-width base count
  localparam logic [6:0] SPAN_WIDE     = 7'd96;
  localparam logic [6:0] SPAN_STANDARD = 7'd80;
  localparam logic [6:0] SPAN_NARROW   = 7'd64;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 3;

  typedef enum logic [2:0] {
    KIND_FREE    = 3'd0,
    KIND_INDEX   = 3'd1,
    KIND_FONT    = 3'd2,
    KIND_BITMAP  = 3'd3,
    KIND_REFRESH = 3'd4
  } slot_kind_t;

  typedef enum logic [1:0] {
    WIDTH_ZERO     = 2'd0,
    WIDTH_NARROW   = 2'd1,
    WIDTH_STANDARD = 2'd2,
    WIDTH_WIDE     = 2'd3
  } pf_width_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLAYFIELD_WIDTH = 3'd0,
    REG_DENSITY_MODE    = 3'd1,
    REG_FINE_SCROLL     = 3'd2,
    REG_INDEX_ENABLE    = 3'd3,
    REG_FONT_ENABLE     = 3'd4,
    REG_BITMAP_ENABLE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] playfield_width;
    logic [1:0] density_mode;
    logic [2:0] fine_scroll;
    logic       index_enable;
    logic       font_enable;
    logic       bitmap_enable;
  } dcss_cfg_t;

  typedef struct packed {
    slot_kind_t fetch_kind;
    logic       refresh_req;
  } dcss_dec_t;

endpackage

`default_nettype wire

### rtl/core/dma_cycle_steal_scheduler_top.sv
`default_nettype none

// Video DMA cycle-steal scheduler. Each input item is one bus cycle slot of a
// scanline (line_start high forces slot 0 of a new line); each result item says
// which slot it was, whether the video DMA takes it (index, font or bitmap fetch,
// or memory refresh) or leaves it free, whether the CPU gets it, and how many CPU
// slots came earlier in the line. Rate is one item per clock unless out_ready
// stalls the result. The slot decode runs in a single combinational pass from the
// line state registers into the result register, and the next item is taken in
// the same cycle that the previous result leaves. Configuration must be written
// through cfg_write/cfg_index/cfg_data while the block is idle; the block does not
// enforce this. Unknown indexes are ignored. The line wraps after LINE_SLOTS slots.

module dma_cycle_steal_scheduler_top import dcss_pkg::*; #(
  parameter int LINE_SLOTS = DEFAULT_LINE_SLOTS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   line_start,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [6:0]                  slot_position,
  output logic [2:0]                  slot_kind,
  output logic                        cpu_gets_slot,
  output logic [6:0]                  cpu_cycles_before
);

  // line length as an 8-bit value so that 128 still compares correctly
  localparam logic [7:0] LINE_SLOTS_W = 8'(LINE_SLOTS);

  dcss_cfg_t  cfg;

  // line state
  logic [6:0] slot_counter;
  logic [6:0] slot_counter_next;
  logic [6:0] cpu_counter;
  logic [6:0] cpu_counter_next;
  logic       refresh_pending;
  logic       refresh_pending_next;

  logic       in_accept;
  logic       wrap;
  logic [6:0] slot;
  logic [6:0] cpu_base;
  logic       pend_merged;
  logic [7:0] slot_inc;
  slot_kind_t kind;
  logic       gets;
  dcss_dec_t  dec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.playfield_width <= WIDTH_STANDARD;
      cfg.density_mode    <= 2'd0;
      cfg.fine_scroll     <= 3'd0;
      cfg.index_enable    <= 1'b0;
      cfg.font_enable     <= 1'b0;
      cfg.bitmap_enable   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PLAYFIELD_WIDTH: cfg.playfield_width <= cfg_data[1:0];
        REG_DENSITY_MODE:    cfg.density_mode    <= cfg_data[1:0];
        REG_FINE_SCROLL:     cfg.fine_scroll     <= cfg_data[2:0];
        REG_INDEX_ENABLE:    cfg.index_enable    <= cfg_data[0];
        REG_FONT_ENABLE:     cfg.font_enable     <= cfg_data[0];
        REG_BITMAP_ENABLE:   cfg.bitmap_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register frees up when its item is taken, so ready follows out_ready
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // new line on request or after the last slot
  assign wrap     = line_start || ({1'b0, slot_counter} >= LINE_SLOTS_W);
  assign slot     = wrap ? 7'd0 : slot_counter;
  assign cpu_base = wrap ? 7'd0 : cpu_counter;

  dcss_fetch_dec u_dec (
    .slot (slot),
    .cfg  (cfg),
    .dec  (dec)
  );

  // a new refresh request merges into one still waiting
  assign pend_merged = (!wrap && refresh_pending) || dec.refresh_req;

  always_comb begin
    kind                 = KIND_FREE;
    refresh_pending_next = 1'b0;
    if (slot < FREE_FROM) begin
      if (dec.fetch_kind != KIND_FREE) begin
        kind                 = dec.fetch_kind;
        refresh_pending_next = pend_merged;
      end else if (pend_merged) begin
        kind                 = KIND_REFRESH;
        refresh_pending_next = 1'b0;
      end
    end
  end

  assign gets = (kind == KIND_FREE);

  // cpu count saturates
  assign cpu_counter_next = (gets && cpu_base != CPU_COUNT_MAX) ? cpu_base + 7'd1 : cpu_base;

  // park at the line length so the next item wraps
  assign slot_inc          = {1'b0, slot} + 8'd1;
  assign slot_counter_next = (slot_inc >= LINE_SLOTS_W) ? LINE_SLOTS_W[6:0] : slot_inc[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter    <= 7'd0;
      cpu_counter     <= 7'd0;
      refresh_pending <= 1'b0;
    end else if (in_accept) begin
      slot_counter    <= slot_counter_next;
      cpu_counter     <= cpu_counter_next;
      refresh_pending <= refresh_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      slot_position     <= slot;
      slot_kind         <= kind;
      cpu_gets_slot     <= gets;
      cpu_cycles_before <= cpu_base;
    end
  end

  // cpu grant matches a free slot
  a_gets_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cpu_gets_slot == (slot_kind == KIND_FREE)))
    else $error("cpu grant disagrees with slot kind");

  // slot counter never runs past the line length
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, slot_counter} <= LINE_SLOTS_W) || (LINE_SLOTS_W == 8'd128))
    else $error("slot counter beyond line length");

  // a line start item reports slot 0 with no earlier cpu slots
  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && line_start) |=>
      (out_valid && slot_position == 7'd0 && cpu_cycles_before == 7'd0))
    else $error("line start not reported as slot 0");

  // fetches never land after the last fetch slot
  a_fetch_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slot_position > FETCH_LAST_SLOT) |->
      (slot_kind == KIND_FREE || slot_kind == KIND_REFRESH))
    else $error("fetch after the fetch window");

  // the end of the line drops a waiting refresh and is always free
  a_line_end: assert property (@(posedge clk) disable iff (rst)
    (in_accept && slot >= FREE_FROM) |=>
      (!refresh_pending && slot_kind == KIND_FREE))
    else $error("end of line slot not free");

endmodule

`default_nettype wire

### rtl/core/dcss_fetch_dec.sv
`default_nettype none

module dcss_fetch_dec import dcss_pkg::*; (
  input  wire logic [6:0] slot,
  input  wire dcss_cfg_t  cfg,
  output dcss_dec_t       dec
);

  logic [5:0] idx_start;
  logic [6:0] span;
  logic [3:0] phase_mask;
  logic       hit_index;
  logic       hit_font;
  logic       hit_bitmap;
  logic [6:0] refresh_ofs;

  // slot lands on a fetch of a stream starting at start
  function automatic logic fetch_hit(input logic [6:0] s, input logic [5:0] start,
                                     input logic [3:0] mask, input logic [6:0] lim);
    logic [6:0] d;
    d = s - {1'b0, start};
    return (s >= {1'b0, start}) && ((d[3:0] & mask) == 4'd0) && (d < lim);
  endfunction

  always_comb begin
    unique case (pf_width_t'(cfg.playfield_width))
      WIDTH_NARROW: begin
        idx_start = WIDE_INDEX_START + 6'd16 + {3'd0, cfg.fine_scroll};
        span      = SPAN_NARROW;
      end
      WIDTH_STANDARD: begin
        idx_start = WIDE_INDEX_START + 6'd8 + {3'd0, cfg.fine_scroll};
        span      = SPAN_STANDARD;
      end
      default: begin
        idx_start = WIDE_INDEX_START + {3'd0, cfg.fine_scroll};
        span      = SPAN_WIDE;
      end
    endcase
  end

  // interval is 2 << mode, so the phase test is a mask of the low bits
  assign phase_mask = 4'((5'd2 << cfg.density_mode) - 5'd1);

  assign hit_index  = cfg.index_enable  && fetch_hit(slot, idx_start, phase_mask, span);
  assign hit_font   = cfg.font_enable   && fetch_hit(slot, idx_start + 6'd3, phase_mask, span);
  assign hit_bitmap = cfg.bitmap_enable && fetch_hit(slot, idx_start + 6'd2, phase_mask, span);

  assign refresh_ofs = slot - REFRESH_FIRST;

  always_comb begin
    dec.fetch_kind  = KIND_FREE;
    dec.refresh_req = 1'b0;
    if (slot <= FETCH_LAST_SLOT) begin
      priority if (hit_bitmap) begin
        dec.fetch_kind = KIND_BITMAP;
      end else if (hit_font) begin
        dec.fetch_kind = KIND_FONT;
      end else if (hit_index) begin
        dec.fetch_kind = KIND_INDEX;
      end else begin
        dec.fetch_kind = KIND_FREE;
      end
      dec.refresh_req = (slot >= REFRESH_FIRST) && (slot <= REFRESH_LAST) &&
                        (refresh_ofs[1:0] == 2'd0);
    end
  end

endmodule

`default_nettype wire

### bench/dcss_checker.sv
`default_nettype none

module dcss_checker import dcss_pkg::*; #(
  parameter int LINE_SLOTS = DEFAULT_LINE_SLOTS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic                   line_start,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [6:0]             slot_position,
  input  wire logic [2:0]             slot_kind,
  input  wire logic                   cpu_gets_slot,
  input  wire logic [6:0]             cpu_cycles_before,
  output int                          fail_count,
  output int                          outstanding
);

  typedef struct {
    logic [6:0] slot;
    slot_kind_t kind;
    logic       gets;
    logic [6:0] cpu_before;
  } slot_decision_t;

  // shadow registers
  pf_width_t cfg_width;
  int        cfg_density;
  int        cfg_scroll;
  logic      cfg_index_en;
  logic      cfg_font_en;
  logic      cfg_bitmap_en;

  // shadow line state
  int   line_pos;
  int   cpu_granted;
  logic refresh_wait;

  slot_decision_t decision_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic on_fetch_grid(int slot, int start, int interval, int count);
    int d;
    if (slot < start) return 1'b0;
    d = slot - start;
    return (d % interval) == 0 && d < count * interval;
  endfunction

  function automatic slot_decision_t predict_slot(logic new_line);
    slot_decision_t d;
    int slot, start, base, interval, count;
    slot_kind_t kind;
    if (new_line || line_pos >= LINE_SLOTS) begin
      slot = 0;
      cpu_granted = 0;
      refresh_wait = 1'b0;
    end else begin
      slot = line_pos;
    end
    start = int'(WIDE_INDEX_START) + cfg_scroll;
    base = 48;
    case (cfg_width)
      WIDTH_STANDARD: begin
        start += 8;
        base = 40;
      end
      WIDTH_NARROW: begin
        start += 16;
        base = 32;
      end
      default: ;
    endcase
    interval = 2 << cfg_density;
    count = base >> cfg_density;
    kind = KIND_FREE;
    if (slot >= int'(FREE_FROM)) begin
      refresh_wait = 1'b0;
    end else begin
      if (slot <= int'(FETCH_LAST_SLOT)) begin
        // later checks win: bitmap over font over index
        if (cfg_index_en && on_fetch_grid(slot, start, interval, count)) kind = KIND_INDEX;
        if (cfg_font_en && on_fetch_grid(slot, start + 3, interval, count)) kind = KIND_FONT;
        if (cfg_bitmap_en && on_fetch_grid(slot, start + 2, interval, count))
          kind = KIND_BITMAP;
        if (slot >= int'(REFRESH_FIRST) && slot <= int'(REFRESH_LAST) &&
            ((slot - int'(REFRESH_FIRST)) % 4) == 0)
          refresh_wait = 1'b1;
      end
      if (kind == KIND_FREE && refresh_wait) begin
        kind = KIND_REFRESH;
        refresh_wait = 1'b0;
      end
    end
    d.slot = slot[6:0];
    d.kind = kind;
    d.gets = (kind == KIND_FREE);
    d.cpu_before = cpu_granted[6:0];
    if (d.gets && cpu_granted < int'(CPU_COUNT_MAX)) cpu_granted++;
    line_pos = (slot + 1) & 127;
    if (slot + 1 >= LINE_SLOTS) line_pos = LINE_SLOTS & 127;
    if (slot + 1 >= LINE_SLOTS && LINE_SLOTS >= 128) line_pos = 0;
    return d;
  endfunction

  function automatic void check_field(string field, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    slot_decision_t exp_d;
    if (rst) begin
      cfg_width     = WIDTH_STANDARD;
      cfg_density   = 0;
      cfg_scroll    = 0;
      cfg_index_en  = 1'b0;
      cfg_font_en   = 1'b0;
      cfg_bitmap_en = 1'b0;
      line_pos      = 0;
      cpu_granted   = 0;
      refresh_wait  = 1'b0;
      decision_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_PLAYFIELD_WIDTH: cfg_width     = pf_width_t'(cfg_data[1:0]);
          REG_DENSITY_MODE:    cfg_density   = int'(cfg_data[1:0]);
          REG_FINE_SCROLL:     cfg_scroll    = int'(cfg_data[2:0]);
          REG_INDEX_ENABLE:    cfg_index_en  = cfg_data[0];
          REG_FONT_ENABLE:     cfg_font_en   = cfg_data[0];
          REG_BITMAP_ENABLE:   cfg_bitmap_en = cfg_data[0];
          default: ;
        endcase
      end
      // result leaving now belongs to an older item, so compare before pushing
      if (out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0d kind %0d",
                   $time, slot_position, slot_kind);
          fail_count++;
        end else begin
          exp_d = decision_q.pop_front();
          check_field("slot_position", exp_d.slot, slot_position);
          check_field("slot_kind", exp_d.kind, slot_kind);
          check_field("cpu_gets_slot", exp_d.gets, cpu_gets_slot);
          check_field("cpu_cycles_before", exp_d.cpu_before, cpu_cycles_before);
        end
      end
      if (in_valid && in_ready) decision_q.push_back(predict_slot(line_start));
    end
    outstanding = decision_q.size();
  end

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb import dcss_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  // cycles to let pass after the last result before touching registers or ending
  localparam int DRAIN_CYCLES = 4;
  // length of the forced receiver hold-off
  localparam int HOLD_CYCLES = 60;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   line_start;
  logic                   out_valid;
  logic                   out_ready;
  logic [6:0]             slot_position;
  logic [2:0]             slot_kind;
  logic                   cpu_gets_slot;
  logic [6:0]             cpu_cycles_before;

  int fail_count;
  int outstanding;
  int cycle_count;

  // shared knobs between the stimulus thread and the receiver thread
  logic quiet;
  int   hold_token;

  dma_cycle_steal_scheduler_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .line_start        (line_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .slot_position     (slot_position),
    .slot_kind         (slot_kind),
    .cpu_gets_slot     (cpu_gets_slot),
    .cpu_cycles_before (cpu_cycles_before)
  );

  dcss_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .line_start        (line_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .slot_position     (slot_position),
    .slot_kind         (slot_kind),
    .cpu_gets_slot     (cpu_gets_slot),
    .cpu_cycles_before (cpu_cycles_before),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  // clock, period 8
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver side: random stalls, a quiet mode, and a long hold-off on request
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (quiet) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= 22);
      end
    end
  end

  // one register write per clock, called at a falling edge
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  task automatic load_config(int width, int density, int scroll, bit ie, bit fe, bit be);
    write_reg(REG_PLAYFIELD_WIDTH, width[CFG_DATA_W-1:0]);
    write_reg(REG_DENSITY_MODE, density[CFG_DATA_W-1:0]);
    write_reg(REG_FINE_SCROLL, scroll[CFG_DATA_W-1:0]);
    write_reg(REG_INDEX_ENABLE, {2'b00, ie});
    write_reg(REG_FONT_ENABLE, {2'b00, fe});
    write_reg(REG_BITMAP_ENABLE, {2'b00, be});
    cfg_write = 1'b0;
  endtask

  // offer one slot tick; entered and left at a falling edge
  task automatic offer_slot(logic new_line);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    line_start = new_line;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pauses until every predicted result has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly whole lines (start then zeros up to the natural wrap), some that run
  // past the wrap point, a few short broken lines, with sparse stray line starts
  task automatic run_line_traffic(int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) len = DEFAULT_LINE_SLOTS;
      else if (r < 88) len = $urandom_range(DEFAULT_LINE_SLOTS + 1, DEFAULT_LINE_SLOTS + 20);
      else len = $urandom_range(1, 20);
      offer_slot(1'b1);
      for (int i = 1; i < len; i++) offer_slot($urandom_range(99) < 2);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_PLAYFIELD_WIDTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    line_start = 1'b0;
    quiet      = 1'b0;
    hold_token = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // first tick straight from reset, with reset configuration
    offer_slot(1'b0);
    wait_drained();

    // directed: wide, densest, all fetches on; start slots, first fetches,
    // bitmap over index collisions, mid-line restart
    load_config(3, 0, 0, 1, 1, 1);
    offer_slot(1'b1);
    for (int i = 0; i < 21; i++) offer_slot(1'b0);
    offer_slot(1'b1);
    offer_slot(1'b0);
    wait_drained();

    // width zero read as wide, density three, largest scroll
    load_config(0, 3, 7, 1, 1, 1);
    run_line_traffic(110);

    // narrow, densest; receiver holds off long so the block fills and stalls
    load_config(1, 0, 0, 1, 1, 1);
    hold_token++;
    run_line_traffic(110);

    // standard, no idling anywhere for this stretch
    load_config(2, 2, 7, 1, 1, 0);
    quiet = 1'b1;
    run_line_traffic(110);
    quiet = 1'b0;

    // no fetches at all: only refresh steals slots
    load_config(3, 1, 3, 0, 0, 0);
    run_line_traffic(110);

    // random settings
    load_config($urandom_range(3), $urandom_range(3), $urandom_range(7),
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    run_line_traffic(110);

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/core/dcss_pkg.sv
rtl/core/dcss_fetch_dec.sv
rtl/core/dma_cycle_steal_scheduler_top.sv
bench/dcss_checker.sv
bench/tb.sv
